### rtl/ils_pkg.sv
package ils_pkg;

	// Default number of cells in the row.
	localparam int unsigned CAPACITY_DEF = 16;

	// Field widths of the request and result items.
	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	// Packed widths of the two tdata buses, filled up to whole bytes.
	localparam int unsigned S_DATA_W = ((FUNC_W + POS_W + VALUE_W + 7) / 8) * 8;
	localparam int unsigned M_DATA_W = ((VALUE_W + 2 + COUNT_W + 7) / 8) * 8;

	// Request codes carried in the func field.
	localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_HEAD   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_TAIL   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_AT     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;

	// What a cell loads on an update.
	typedef enum logic [1:0] {
		MOVE_HOLD  = 2'd0,
		MOVE_NEW   = 2'd1,
		MOVE_LOWER = 2'd2,
		MOVE_UPPER = 2'd3
	} move_t;

endpackage

### rtl/ils_cell.sv
module ils_cell
	import ils_pkg::*;
(
	input  logic                      clk,
	input  move_t                     move,
	input  logic signed [VALUE_W-1:0] new_value,
	input  logic signed [VALUE_W-1:0] lower_value,
	input  logic signed [VALUE_W-1:0] upper_value,
	input  logic                      tap_sel,
	output logic signed [VALUE_W-1:0] value,
	output logic signed [VALUE_W-1:0] tap
);

	logic signed [VALUE_W-1:0] value_q;

	always_ff @(posedge clk) begin
		unique case (move)
			MOVE_HOLD:  value_q <= value_q;
			MOVE_NEW:   value_q <= new_value;
			MOVE_LOWER: value_q <= lower_value;
			MOVE_UPPER: value_q <= upper_value;
			default:    value_q <= value_q;
		endcase
	end

	assign value = value_q;
	// Masked so that the read taps of all cells can simply be ORed together.
	assign tap = tap_sel ? value_q : '0;

endmodule

### rtl/indexed_list_store.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Each request reads, inserts (head, tail or before a position) or deletes at a
// position and returns exactly one result with the read value, a hit flag, an
// accepted flag and the length after the request. The whole row shifts by one
// cell at once, so an item can be taken every cycle and its result is
// valid in the cycle after it was accepted. While a result waits in the output
// register, no further item is accepted.
// Inserts into a full list and inserts or deletes past the end leave the list
// unchanged and report accepted as zero. count_now carries the low five bits
// of the length. No clearing pass runs after reset.
module indexed_list_store
	import ils_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [2:0] func, [7:3] position, [39:8] item_value
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [31:0] read_value, [32] hit, [33] accepted, [38:34] count_now, [39] zero
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
	// Only cells below 2**POS_W can be named by a read.
	localparam int unsigned TAPS = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

	logic [CW-1:0] count_q;
	logic          m_tvalid_q;
	logic signed [VALUE_W-1:0] read_value_q;
	logic          hit_q;
	logic          accepted_q;
	logic [COUNT_W-1:0] count_now_q;

	logic [FUNC_W-1:0]         func;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] item_value;
	logic                      accept;
	logic [CMPW-1:0]           pos_ext;
	logic [CMPW-1:0]           count_ext;
	logic [CMPW-1:0]           slot;
	logic [CMPW-1:0]           next_count;
	logic                      room;
	logic                      hit;
	logic                      ins_ok;
	logic                      del_ok;
	logic signed [VALUE_W-1:0] read_value;

	logic signed [VALUE_W-1:0] cell_value [CAPACITY];
	logic signed [VALUE_W-1:0] cell_tap   [CAPACITY];

	assign func       = s_tdata[FUNC_W-1:0];
	assign position   = s_tdata[FUNC_W +: POS_W];
	assign item_value = s_tdata[FUNC_W+POS_W +: VALUE_W];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos_ext   = CMPW'(position);
	assign count_ext = CMPW'(count_q);
	assign room      = count_ext != CMPW'(CAPACITY);

	always_comb begin
		hit    = (func == FUNC_READ) && (pos_ext < count_ext);
		ins_ok = room && ((func == FUNC_HEAD) || (func == FUNC_TAIL) ||
			((func == FUNC_AT) && (pos_ext <= count_ext)));
		del_ok = (func == FUNC_DELETE) && (pos_ext < count_ext);
		priority if (func == FUNC_HEAD) begin
			slot = '0;
		end else if (func == FUNC_TAIL) begin
			slot = count_ext;
		end else begin
			slot = pos_ext;
		end
		priority if (ins_ok) begin
			next_count = count_ext + CMPW'(1);
		end else if (del_ok) begin
			next_count = count_ext - CMPW'(1);
		end else begin
			next_count = count_ext;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CMPW-1:0] IDX = CMPW'(i);
		move_t                     move;
		logic                      tap_sel;
		logic signed [VALUE_W-1:0] lower_value;
		logic signed [VALUE_W-1:0] upper_value;

		if (i == 0) begin : g_first
			assign lower_value = item_value;
		end else begin : g_inner_lo
			assign lower_value = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_value = cell_value[i];
		end else begin : g_inner_hi
			assign upper_value = cell_value[i+1];
		end
		if (i < TAPS) begin : g_tap
			assign tap_sel = hit && (position == POS_W'(i));
		end else begin : g_no_tap
			assign tap_sel = 1'b0;
		end

		always_comb begin
			priority if (accept && ins_ok && (IDX == slot)) begin
				move = MOVE_NEW;
			end else if (accept && ins_ok && (IDX > slot)) begin
				move = MOVE_LOWER;
			end else if (accept && del_ok && (IDX >= slot)) begin
				move = MOVE_UPPER;
			end else begin
				move = MOVE_HOLD;
			end
		end

		ils_cell u_cell (
			.clk         (clk),
			.move        (move),
			.new_value   (item_value),
			.lower_value (lower_value),
			.upper_value (upper_value),
			.tap_sel     (tap_sel),
			.value       (cell_value[i]),
			.tap         (cell_tap[i])
		);
	end

	always_comb begin
		read_value = '0;
		for (int i = 0; i < TAPS; i++) begin
			read_value = read_value | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= next_count[CW-1:0];
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_value;
			hit_q        <= hit;
			accepted_q   <= ins_ok || del_ok;
			count_now_q  <= next_count[COUNT_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'({count_now_q, accepted_q, hit_q, read_value_q});

endmodule

### rtl/ils_checker.sv
module ils_checker
	import ils_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	// A request is either a read or a change, never reported as both.
	a_hit_excl_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[VALUE_W] && m_tdata[VALUE_W+1]))
		else $error("hit and accepted both set");

	// Anything but a read hit returns a zero value.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[VALUE_W] |-> m_tdata[VALUE_W-1:0] == '0)
		else $error("nonzero read value without hit");

	// The reported length never exceeds the number of cells.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAPACITY >= (1 << COUNT_W)) ||
			(32'(m_tdata[VALUE_W+2 +: COUNT_W]) <= CAPACITY))
		else $error("count exceeds capacity");

	// An accepted item yields a result in the next cycle.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item gave no result");

	// A result that waits holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("waiting result changed");

endmodule

bind indexed_list_store ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
